// ===== design/lcm_pkg.sv =====
// Package for the running hyperperiod block: widths and sequencer state type.
package lcm_pkg;

    localparam int PERIOD_BITS = 16;
    localparam int RESULT_BITS = 32;
    localparam int PROD_BITS   = RESULT_BITS + PERIOD_BITS;
    localparam int HYPER_W     = 32;
    localparam int PERIOD_W    = 16;
    localparam int DIV_CNT_W   = $clog2(RESULT_BITS);
    localparam int MUL_CNT_W   = (PERIOD_BITS > 1) ? $clog2(PERIOD_BITS) : 1;
    localparam int TWOS_W      = $clog2(PERIOD_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWOS,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

// ===== design/running_lcm_of_periods.sv =====
// Running hyperperiod: least common multiple of task periods, one period per word.
//
//  channel  | dir | tdata                      | tuser                          | tlast
//  s_axis   | in  | [15:0] period              | -                              | last_of_set
//  m_axis   | out | [31:0] hyperperiod         | [0] overflow, [1] bad_period   | set_done
//
// One word at a time: s_axis_tready is high only while the sequencer is idle.
// A first, zero or saturated period goes straight to the done state; a later period
// runs a binary GCD (one subtract or shift per cycle), a restoring divide and a
// shift-add multiply.
// The result register frees the input side; a stalled m_axis holds the sequencer
// at its last step. Reset (i_rst_n low, synchronous) closes any open set.
module running_lcm_of_periods
    import lcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PERIOD_W-1:0] s_axis_tdata,   // [15:0] period
    input  logic                s_axis_tlast,   // last_of_set
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [HYPER_W-1:0]  m_axis_tdata,   // [31:0] hyperperiod
    output logic [1:0]          m_axis_tuser,   // [0] overflow, [1] bad_period
    output logic                m_axis_tlast    // set_done
);

    localparam logic [RESULT_BITS-1:0] MAXV = '1;

    t_state r_state, n_state;

    logic [RESULT_BITS-1:0] r_lcm;
    logic                   r_open;
    logic                   r_ovf;
    logic [PERIOD_BITS-1:0] r_p;
    logic                   r_last;
    logic                   r_bad;

    logic [RESULT_BITS-1:0] r_a;
    logic [PERIOD_BITS-1:0] r_b;
    logic [TWOS_W-1:0]      r_k;
    logic [PERIOD_BITS-1:0] r_g;
    logic [PERIOD_BITS-1:0] r_rem;
    logic [RESULT_BITS-1:0] r_dq;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [PROD_BITS-1:0]   r_acc;
    logic [PERIOD_BITS-1:0] r_pm;
    logic [MUL_CNT_W-1:0]   r_mul_cnt;

    logic                   r_out_valid;
    logic [HYPER_W-1:0]     r_out_hp;
    logic                   r_out_ovf;
    logic                   r_out_bad;
    logic                   r_out_last;

    logic                   in_fire;
    logic                   out_free;
    logic [PERIOD_BITS-1:0] in_p;
    logic                   in_bad;
    logic                   simple_case;
    logic                   gcd_done;
    logic                   a_ge_b;
    logic [PERIOD_BITS:0]   rem_sh;
    logic                   rem_ge;
    logic [PROD_BITS-1:0]   acc_sh;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign in_p     = PERIOD_BITS'(s_axis_tdata);
    assign in_bad   = (in_p == '0);

    // Everything except an ordinary later period in an unsaturated set is settled at once.
    assign simple_case = in_bad || !r_open || r_ovf || (r_lcm == '0);

    assign gcd_done = (r_a == '0);
    assign a_ge_b   = (r_a >= RESULT_BITS'(r_b));
    assign rem_sh   = {r_rem, r_dq[RESULT_BITS-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_g});
    assign acc_sh   = {r_acc[PROD_BITS-2:0], 1'b0}
                    + (r_pm[PERIOD_BITS-1] ? PROD_BITS'(r_dq) : '0);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = simple_case ? ST_DONE : ST_TWOS;
                end
            end
            ST_TWOS: begin
                if (r_a[0] || r_b[0]) begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(RESULT_BITS - 1)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_mul_cnt == MUL_CNT_W'(PERIOD_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_hp;
        m_axis_tuser  = {r_out_bad, r_out_ovf};
        m_axis_tlast  = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcm       <= '0;
            r_open      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_p    <= in_p;
                        r_last <= s_axis_tlast;
                        r_bad  <= in_bad;
                        if (!in_bad) begin
                            if (!r_open) begin
                                r_open <= 1'b1;
                                if (PROD_BITS'(in_p) > PROD_BITS'(MAXV)) begin
                                    r_lcm <= MAXV;
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_lcm <= RESULT_BITS'(in_p);
                                    r_ovf <= 1'b0;
                                end
                            end else if (r_ovf || (r_lcm == '0)) begin
                                r_lcm <= MAXV;
                            end
                        end
                        r_a <= r_lcm;
                        r_b <= in_p;
                        r_k <= '0;
                    end
                end
                ST_TWOS: begin
                    // Strip the common factors of two before the odd-only loop.
                    if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_GCD: begin
                    if (gcd_done) begin
                        r_g       <= PERIOD_BITS'(r_b << r_k);
                        r_rem     <= '0;
                        r_dq      <= r_lcm;
                        r_div_cnt <= '0;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (a_ge_b) begin
                        r_a <= r_a - RESULT_BITS'(r_b);
                    end else begin
                        r_b <= r_b - PERIOD_BITS'(r_a);
                    end
                end
                ST_DIV: begin
                    // Restoring divide: the dividend shifts out as the quotient shifts in.
                    r_rem     <= rem_ge ? PERIOD_BITS'(rem_sh - {1'b0, r_g})
                                        : PERIOD_BITS'(rem_sh);
                    r_dq      <= {r_dq[RESULT_BITS-2:0], rem_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(RESULT_BITS - 1)) begin
                        r_acc     <= '0;
                        r_pm      <= r_p;
                        r_mul_cnt <= '0;
                    end
                end
                ST_MUL: begin
                    r_acc     <= acc_sh;
                    r_pm      <= r_pm << 1;
                    r_mul_cnt <= r_mul_cnt + 1'b1;
                    if (r_mul_cnt == MUL_CNT_W'(PERIOD_BITS - 1)) begin
                        if (acc_sh[PROD_BITS-1:RESULT_BITS] != '0) begin
                            r_lcm <= MAXV;
                            r_ovf <= 1'b1;
                        end else begin
                            r_lcm <= acc_sh[RESULT_BITS-1:0];
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_hp    <= r_open ? HYPER_W'(r_lcm) : '0;
                        r_out_ovf   <= r_open && r_ovf;
                        r_out_bad   <= r_bad;
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_open <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
